[design/kdef_pkg.sv]
// Shared types and constants for the key debounce event FIFO.
`timescale 1ns / 1ps
`default_nettype none

package kdef_pkg;

    localparam int FILTER_W   = 7;
    localparam int TICK_W     = 16;
    localparam int CNT_W      = 8;
    localparam int CODE_W     = 5;
    localparam int OUT_CODE_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FILTER_W-1:0] FILTER_RESET = 7'd5;
    localparam logic [TICK_W-1:0]   LONG_RESET   = 16'd100;
    localparam logic [TICK_W-1:0]   REPEAT_RESET = 16'd0;
    localparam logic [CNT_W-1:0]    CNT_RESET    = CNT_W'(FILTER_RESET / 2);

    localparam logic [CFG_IDX_W-1:0] REG_FILTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd2;

    localparam logic [CODE_W-1:0] CODE_DOWN = 5'd1;
    localparam logic [CODE_W-1:0] CODE_UP   = 5'd2;
    localparam logic [CODE_W-1:0] CODE_LONG = 5'd3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic push2;
        logic rd_load;
        logic clear;
    } kdef_cmd_t;

    typedef struct packed {
        logic last_key;
        logic push_b;
        logic out_busy;
        op_t  op;
    } kdef_sts_t;

endpackage

`default_nettype wire

[design/kdef_if.sv]
// Channel interfaces for request words and event words.
`timescale 1ns / 1ps
`default_nettype none

interface kdef_req_if #(
    parameter int NUM_KEYS = 4
);
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [NUM_KEYS-1:0] key_down;

    modport source (output valid, output op, output key_down, input ready);
    modport sink (input valid, input op, input key_down, output ready);
endinterface

interface kdef_evt_if;
    logic       valid;
    logic       ready;
    logic [3:0] key_code;
    logic       fifo_empty;

    modport source (output valid, output key_code, output fifo_empty, input ready);
    modport sink (input valid, input key_code, input fifo_empty, output ready);
endinterface

`default_nettype wire

[design/kdef_ctrl.sv]
// Controller state machine that sequences ticks, reads and clears.
`timescale 1ns / 1ps
`default_nettype none

module kdef_ctrl
    import kdef_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           in_ready,
    output kdef_cmd_t      cmd,
    input  wire kdef_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_PUSH2,
        S_READ,
        S_CLEAR
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    OP_TICK:  state_next = S_SCAN;
                    OP_READ:  state_next = S_READ;
                    OP_CLEAR: state_next = S_CLEAR;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.push_b)
                    state_next = S_PUSH2;
                else if (sts.last_key)
                    state_next = S_IDLE;
            end
            S_PUSH2:
            begin
                cmd.push2  = 1'b1;
                state_next = sts.last_key ? S_IDLE : S_SCAN;
            end
            S_READ:
            begin
                if (!sts.out_busy)
                begin
                    cmd.rd_load = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[design/kdef_datapath.sv]
// Datapath with key state, configuration registers, event memory and output register.
`timescale 1ns / 1ps
`default_nettype none

module kdef_datapath
    import kdef_pkg::*;
#(
    parameter int NUM_KEYS   = 4,
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [1:0]            op_in,
    input  wire logic [NUM_KEYS-1:0]   keys_in,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       evt_valid,
    input  wire logic                  evt_ready,
    output logic [OUT_CODE_W-1:0]      evt_code,
    output logic                       evt_empty,
    input  wire kdef_cmd_t             cmd,
    output kdef_sts_t                  sts
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

    logic [FILTER_W-1:0] filter_reg;
    logic [TICK_W-1:0]   long_ticks_reg;
    logic [TICK_W-1:0]   repeat_reg;

    op_t                 op_reg;
    logic [NUM_KEYS-1:0] keys_reg;
    logic [KEY_W-1:0]    idx_reg;

    logic [CNT_W-1:0]  cnt_reg     [NUM_KEYS];
    logic              pressed_reg [NUM_KEYS];
    logic [TICK_W-1:0] long_reg    [NUM_KEYS];
    logic [TICK_W-1:0] rep_reg     [NUM_KEYS];

    logic [CODE_W-1:0] mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CODE_W-1:0] code_b_reg;

    logic                  out_valid_reg;
    logic [OUT_CODE_W-1:0] out_code_reg;
    logic                  out_empty_reg;

    logic [CNT_W-1:0]  cnt_next;
    logic              pressed_next;
    logic [TICK_W-1:0] long_next;
    logic [TICK_W-1:0] rep_next;
    logic              push_a;
    logic              push_b;
    logic [CODE_W-1:0] code_a;
    logic [CODE_W-1:0] code_2;
    logic              press_push;
    logic              hold_push;
    logic [CODE_W-1:0] base;
    logic [CNT_W-1:0]  f_ext;
    logic [CNT_W-1:0]  two_f;
    logic [CNT_W-1:0]  cnt_cur;
    logic [TICK_W-1:0] long_inc;
    logic [TICK_W-1:0] rep_inc;
    logic              wr_en;
    logic [CODE_W-1:0] wr_data;
    logic              fifo_is_empty;

    always_comb
    begin
        cnt_cur      = cnt_reg[idx_reg];
        f_ext        = {1'b0, filter_reg};
        two_f        = {filter_reg, 1'b0};
        base         = (CODE_W'(idx_reg) << 1) + CODE_W'(idx_reg);
        long_inc     = long_reg[idx_reg] + TICK_W'(1);
        rep_inc      = rep_reg[idx_reg] + TICK_W'(1);
        cnt_next     = cnt_cur;
        pressed_next = pressed_reg[idx_reg];
        long_next    = long_reg[idx_reg];
        rep_next     = rep_reg[idx_reg];
        press_push   = 1'b0;
        hold_push    = 1'b0;
        code_2       = base + CODE_LONG;
        if (keys_reg[idx_reg])
        begin
            if (cnt_cur < f_ext)
                cnt_next = f_ext;
            else if (cnt_cur < two_f)
                cnt_next = cnt_cur + CNT_W'(1);
            else
            begin
                if (!pressed_reg[idx_reg])
                begin
                    pressed_next = 1'b1;
                    press_push   = 1'b1;
                end
                if (long_ticks_reg != '0)
                begin
                    if (long_reg[idx_reg] < long_ticks_reg)
                    begin
                        long_next = long_inc;
                        hold_push = (long_inc >= long_ticks_reg);
                    end
                    else if (repeat_reg != '0)
                    begin
                        rep_next = rep_inc;
                        if (rep_inc >= repeat_reg)
                        begin
                            rep_next  = '0;
                            hold_push = 1'b1;
                            code_2    = base + CODE_DOWN;
                        end
                    end
                end
            end
        end
        else
        begin
            if (cnt_cur > f_ext)
                cnt_next = f_ext;
            else if (cnt_cur != '0)
                cnt_next = cnt_cur - CNT_W'(1);
            else if (pressed_reg[idx_reg])
            begin
                pressed_next = 1'b0;
                press_push   = 1'b1;
            end
            long_next = '0;
            rep_next  = '0;
        end
        push_a = press_push || hold_push;
        push_b = press_push && hold_push;
        if (press_push)
            code_a = keys_reg[idx_reg] ? (base + CODE_DOWN) : (base + CODE_UP);
        else
            code_a = code_2;
    end

    assign wr_en         = (cmd.scan && push_a) || cmd.push2;
    assign wr_data       = cmd.push2 ? code_b_reg : code_a;
    assign fifo_is_empty = (rd_ptr_reg == wr_ptr_reg);

    always_comb
    begin
        sts.last_key = (idx_reg == LAST_KEY);
        sts.push_b   = push_b;
        sts.out_busy = out_valid_reg && !evt_ready;
        sts.op       = op_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg     <= FILTER_RESET;
            long_ticks_reg <= LONG_RESET;
            repeat_reg     <= REPEAT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FILTER: filter_reg     <= cfg_data[FILTER_W-1:0];
                REG_LONG:   long_ticks_reg <= cfg_data[TICK_W-1:0];
                REG_REPEAT: repeat_reg     <= cfg_data[TICK_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_TICK;
            keys_reg <= '0;
            idx_reg  <= '0;
        end
        else if (cmd.capture)
        begin
            op_reg   <= op_t'(op_in);
            keys_reg <= keys_in;
            idx_reg  <= '0;
        end
        else if ((cmd.scan && !push_b) || cmd.push2)
        begin
            if (idx_reg != LAST_KEY)
                idx_reg <= idx_reg + KEY_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                cnt_reg[k]     <= CNT_RESET;
                pressed_reg[k] <= 1'b0;
                long_reg[k]    <= '0;
                rep_reg[k]     <= '0;
            end
        end
        else if (cmd.scan)
        begin
            cnt_reg[idx_reg]     <= cnt_next;
            pressed_reg[idx_reg] <= pressed_next;
            long_reg[idx_reg]    <= long_next;
            rep_reg[idx_reg]     <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && push_b)
            code_b_reg <= code_2;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (cmd.clear)
                rd_ptr_reg <= wr_ptr_reg;
            else if (cmd.rd_load && !fifo_is_empty)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_load)
        begin
            out_code_reg  <= fifo_is_empty ? '0 : mem[rd_ptr_reg][OUT_CODE_W-1:0];
            out_empty_reg <= fifo_is_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.rd_load)
            out_valid_reg <= 1'b1;
        else if (evt_ready)
            out_valid_reg <= 1'b0;
    end

    assign evt_valid = out_valid_reg;
    assign evt_code  = out_code_reg;
    assign evt_empty = out_empty_reg;

    a_push2_follows_dual: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push2 |-> $past(cmd.scan && push_b))
        else $error("second word written without a dual push");

    a_load_needs_free_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_load |-> !(out_valid_reg && !evt_ready))
        else $error("output register overwritten while a word waits");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (rd_ptr_reg == $past(wr_ptr_reg)))
        else $error("clear did not empty the event FIFO");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.rd_load))
        else $error("output word appeared without a read");

endmodule

`default_nettype wire

[design/key_debounce_event_fifo.sv]
// Top level: debounced key scanner feeding an event FIFO with long press and repeat.
// A tick word scans the keys in turn, with an extra step for each key that pushes two codes.
// A read word loads its event word into the output register, waiting while it is held.
// Every word passes accept and decode; tick, read and clear words then step the sequencer.
// Barring those extra steps the scan takes one key and at most one memory write per cycle.
// Reset clears key state, pointers and control registers at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_event_fifo
    import kdef_pkg::*;
#(
    parameter int NUM_KEYS   = 4,
    parameter int FIFO_DEPTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    kdef_req_if.sink                   req,
    kdef_evt_if.source                 evt,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    kdef_cmd_t cmd;
    kdef_sts_t sts;
    logic      in_ready;

    kdef_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    kdef_datapath #(
        .NUM_KEYS   (NUM_KEYS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_in     (req.op),
        .keys_in   (req.key_down),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt_valid (evt.valid),
        .evt_ready (evt.ready),
        .evt_code  (evt.key_code),
        .evt_empty (evt.fifo_empty),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign req.ready = in_ready;

endmodule

`default_nettype wire

[tb/sv/key_debounce_event_fifo_tb.sv]
// Self-checking testbench for the key debounce event FIFO with random stalls on both channels.
`timescale 1ns / 1ps

module key_debounce_event_fifo_tb
    import kdef_pkg::*;
();

    localparam int NUM_KEYS      = 4;
    localparam int FIFO_DEPTH    = 16;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_WORDS  = 1100;
    localparam int HOLD_OFF      = 300;

    localparam logic [1:0]           OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [OUT_CODE_W-1:0] code;
        logic                  empty;
    } event_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kdef_req_if #(.NUM_KEYS(NUM_KEYS)) req_ch ();
    kdef_evt_if evt_ch ();

    key_debounce_event_fifo #(
        .NUM_KEYS(NUM_KEYS),
        .FIFO_DEPTH(FIFO_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .evt(evt_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [FILTER_W-1:0] cur_filter;
    logic [TICK_W-1:0]   cur_long;
    logic [TICK_W-1:0]   cur_repeat;
    logic [CNT_W-1:0]    deb_count [NUM_KEYS];
    logic                key_held [NUM_KEYS];
    logic [TICK_W-1:0]   held_ticks [NUM_KEYS];
    logic [TICK_W-1:0]   since_repeat [NUM_KEYS];
    logic [CODE_W-1:0]   code_mem [FIFO_DEPTH];
    int                  rd_ptr;
    int                  wr_ptr;

    event_word_t pending_events[$];

    int errors;
    int words_sent;
    int reads_checked;
    int codes_seen;
    int settings_written;
    int sink_hold_cycles;
    bit no_idle;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void reset_predictor();
        cur_filter = FILTER_RESET;
        cur_long   = LONG_RESET;
        cur_repeat = REPEAT_RESET;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            deb_count[k]    = CNT_RESET;
            key_held[k]     = 1'b0;
            held_ticks[k]   = '0;
            since_repeat[k] = '0;
        end
        for (int i = 0; i < FIFO_DEPTH; i++)
            code_mem[i] = '0;
        rd_ptr = 0;
        wr_ptr = 0;
    endfunction

    function automatic void push_key_code(logic [CODE_W-1:0] code);
        code_mem[wr_ptr] = code;
        wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
    endfunction

    function automatic void debounce_key(int k, logic down);
        int unsigned       f;
        logic [CODE_W-1:0] base;
        f = cur_filter;
        base = CODE_W'(3 * k);
        if (down)
        begin
            if (deb_count[k] < f)
                deb_count[k] = CNT_W'(f);
            else if (deb_count[k] < 2 * f)
                deb_count[k] = deb_count[k] + 1'b1;
            else
            begin
                if (!key_held[k])
                begin
                    key_held[k] = 1'b1;
                    push_key_code(base + CODE_DOWN);
                end
                if (cur_long != 0)
                begin
                    if (held_ticks[k] < cur_long)
                    begin
                        held_ticks[k] = held_ticks[k] + 1'b1;
                        if (held_ticks[k] >= cur_long)
                            push_key_code(base + CODE_LONG);
                    end
                    else if (cur_repeat != 0)
                    begin
                        since_repeat[k] = since_repeat[k] + 1'b1;
                        if (since_repeat[k] >= cur_repeat)
                        begin
                            since_repeat[k] = '0;
                            push_key_code(base + CODE_DOWN);
                        end
                    end
                end
            end
        end
        else
        begin
            if (deb_count[k] > f)
                deb_count[k] = CNT_W'(f);
            else if (deb_count[k] > 0)
                deb_count[k] = deb_count[k] - 1'b1;
            else if (key_held[k])
            begin
                key_held[k] = 1'b0;
                push_key_code(base + CODE_UP);
            end
            held_ticks[k]   = '0;
            since_repeat[k] = '0;
        end
    endfunction

    function automatic void apply_request(logic [1:0] op, logic [NUM_KEYS-1:0] keys);
        event_word_t word;
        if (op == OP_TICK)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
                debounce_key(k, keys[k]);
        end
        else if (op == OP_READ)
        begin
            if (rd_ptr == wr_ptr)
            begin
                word.code  = '0;
                word.empty = 1'b1;
            end
            else
            begin
                word.code  = code_mem[rd_ptr][OUT_CODE_W-1:0];
                word.empty = 1'b0;
                rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
            end
            pending_events.push_back(word);
        end
        else if (op == OP_CLEAR)
            rd_ptr = wr_ptr;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(logic [1:0] op, logic [NUM_KEYS-1:0] keys);
        int gap;
        gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.key_down <= keys;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        apply_request(op, keys);
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FILTER: cur_filter = data[FILTER_W-1:0];
            REG_LONG:   cur_long = data;
            REG_REPEAT: cur_repeat = data;
            default: ;
        endcase
    endtask

    task automatic set_timing(logic [CFG_DATA_W-1:0] filter_data,
                              logic [CFG_DATA_W-1:0] long_data,
                              logic [CFG_DATA_W-1:0] repeat_data);
        write_reg(REG_FILTER, filter_data);
        write_reg(REG_LONG, long_data);
        write_reg(REG_REPEAT, repeat_data);
        settings_written++;
    endtask

    task automatic test_reset_values();
        send_word(OP_READ, 4'h0);
        repeat (7) send_word(OP_TICK, 4'hF);
        repeat (5) send_word(OP_READ, 4'hF);
    endtask

    task automatic test_filter_zero_overflow();
        wait_drained();
        set_timing(16'd0, 16'd1, 16'd1);
        repeat (2) send_word(OP_TICK, 4'h0);
        repeat (3) send_word(OP_TICK, 4'hF);
        repeat (5) send_word(OP_READ, 4'h0);
    endtask

    task automatic test_clear_and_unused_op();
        send_word(OP_TICK, 4'h5);
        send_word(OP_UNUSED, 4'hA);
        send_word(OP_CLEAR, 4'hF);
        send_word(OP_READ, 4'h0);
    endtask

    task automatic test_register_extremes();
        wait_drained();
        set_timing(16'd127, 16'hFFFF, 16'hFFFF);
        repeat (3) send_word(OP_TICK, 4'hF);
        wait_drained();
        write_reg(REG_UNUSED, 16'hFFFF);
        // Filter of 20 with junk in the unused upper bits; held counts now lie above twice it.
        set_timing(16'hFF94, 16'd1, 16'hFFFF);
        send_word(OP_TICK, 4'hF);
        repeat (3) send_word(OP_READ, 4'h0);
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        set_timing(16'd0, 16'd2, 16'd1);
        no_idle = 1'b1;
        repeat (4) send_word(OP_TICK, 4'hF);
        sink_hold_cycles = HOLD_OFF;
        repeat (24) send_word(OP_READ, 4'h0);
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_sequences();
        int                    target;
        int                    r;
        int                    cap;
        int                    backlog;
        logic [FILTER_W-1:0]   f;
        logic [CFG_DATA_W-1:0] l;
        logic [CFG_DATA_W-1:0] rp;
        logic [NUM_KEYS-1:0]   pattern;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            wait_drained();
            if ($urandom_range(0, 7) == 0)
            begin
                f  = FILTER_W'($urandom_range(64, 127));
                l  = CFG_DATA_W'($urandom_range(0, 65535));
                rp = CFG_DATA_W'($urandom_range(0, 65535));
            end
            else
            begin
                f  = FILTER_W'($urandom_range(0, 4));
                l  = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
                rp = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
            end
            if ($urandom_range(0, 1) == 0)
                set_timing({9'($urandom_range(0, 511)), f}, l, rp);
            else
                set_timing(16'(f), l, rp);
            no_idle = ($urandom_range(0, 5) == 0);
            repeat ($urandom_range(6, 12))
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    pattern = NUM_KEYS'($urandom_range(0, 15));
                    cap = 2 * cur_filter + cur_long + 3 * cur_repeat + 4;
                    if (cap > 40)
                        cap = 40;
                    repeat ($urandom_range(1, cap))
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_word(OP_TICK,
                                      pattern ^ NUM_KEYS'(1 << $urandom_range(0, NUM_KEYS - 1)));
                        else
                            send_word(OP_TICK, pattern);
                        if ($urandom_range(0, 99) < 25)
                            send_word(OP_READ, NUM_KEYS'($urandom_range(0, 15)));
                    end
                end
                else if (r < 78)
                begin
                    repeat ($urandom_range(1, 6))
                        send_word(OP_TICK, NUM_KEYS'($urandom_range(0, 15)));
                end
                else if (r < 90)
                begin
                    repeat ($urandom_range(1, 8))
                        send_word(OP_READ, NUM_KEYS'($urandom_range(0, 15)));
                end
                else if (r < 95)
                begin
                    send_word(OP_CLEAR, NUM_KEYS'($urandom_range(0, 15)));
                    send_word(OP_READ, NUM_KEYS'($urandom_range(0, 15)));
                end
                else
                    send_word(OP_UNUSED, NUM_KEYS'($urandom_range(0, 15)));
            end
            if ($urandom_range(0, 1) == 0)
            begin
                backlog = (wr_ptr - rd_ptr + FIFO_DEPTH) % FIFO_DEPTH;
                repeat (backlog + 1)
                    send_word(OP_READ, NUM_KEYS'($urandom_range(0, 15)));
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        evt_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall_left;
            @(negedge clk);
            if (sink_hold_cycles > 0)
            begin
                evt_ch.ready <= 1'b0;
                sink_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                evt_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (!no_idle && $urandom_range(0, 99) < 25)
            begin
                evt_ch.ready <= 1'b0;
                stall_left = pick_gap() - 1;
            end
            else
                evt_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        event_word_t want;
        if (rst_n && evt_ch.valid && evt_ch.ready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("Event word with no read waiting: key_code %0d fifo_empty %0b",
                       evt_ch.key_code, evt_ch.fifo_empty);
                errors++;
            end
            else
            begin
                want = pending_events.pop_front();
                reads_checked++;
                if (!want.empty)
                    codes_seen++;
                if (evt_ch.key_code !== want.code)
                begin
                    $error("key_code: expected %0d, got %0d", want.code, evt_ch.key_code);
                    errors++;
                end
                if (evt_ch.fifo_empty !== want.empty)
                begin
                    $error("fifo_empty: expected %0b, got %0b", want.empty, evt_ch.fifo_empty);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (evt_ch.valid && evt_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("key_debounce_event_fifo_tb NOT OK");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.op       = OP_TICK;
        req_ch.key_down = '0;
        errors           = 0;
        words_sent       = 0;
        reads_checked    = 0;
        codes_seen       = 0;
        settings_written = 1;
        sink_hold_cycles = 0;
        no_idle          = 1'b0;
        reset_predictor();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_filter_zero_overflow();
        test_clear_and_unused_op();
        test_register_extremes();
        test_output_backpressure();
        test_random_sequences();
        wait_drained();

        $display("Run covered %0d request words and %0d checked reads, %0d of them key codes,",
                 words_sent, reads_checked, codes_seen);
        $display("over %0d register settings from filter 0 up to full-scale timers.",
                 settings_written);
        if (errors == 0 && pending_events.size() == 0)
            $display("key_debounce_event_fifo_tb OK");
        else
            $display("key_debounce_event_fifo_tb NOT OK");
        $finish;
    end

endmodule
